// File: sv/lc3b_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lc3b_pkg;

    // Transaction kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_STEP    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    // Opcodes
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LDB  = 4'd2;
    localparam logic [3:0] OP_STB  = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDW  = 4'd6;
    localparam logic [3:0] OP_STW  = 4'd7;
    localparam logic [3:0] OP_XOR  = 4'd9;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_SHF  = 4'd13;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    // Flag codes, N in bit 2, Z in bit 1, P in bit 0
    localparam logic [2:0] FLAGS_N = 3'b100;
    localparam logic [2:0] FLAGS_Z = 3'b010;
    localparam logic [2:0] FLAGS_P = 3'b001;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] load_address;
        logic [15:0] load_data;
    } item_t;

    typedef struct packed {
        logic [15:0] pc_after;
        logic        flag_n;
        logic        flag_z;
        logic        flag_p;
        logic        reg_write;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_write;
        logic [15:0] mem_byte_address;
        logic [15:0] mem_value;
        logic        mem_byte_only;
        logic        halted;
    } result_t;

endpackage

`default_nettype wire

// File: sv/lc3b_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lc3b_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: sv/lc3b_instruction_executor.sv
`timescale 1ns / 1ps
`default_nettype none

// LC-3b core, one transaction at a time. After reset the block sweeps
// MEM_WORDS addresses clearing main memory and the register file, with busy
// high. A load, restart or no-op transaction, or a step refused because the
// PC is zero, answers with done in the cycle after start; a step at a nonzero
// PC answers after S_FETCH, S_DEC, S_RA and S_RB, since main memory and the
// register file each have one port with a registered read: fetch, read the
// first source, read the second source, data access, then write back.
// The receiver cannot stall: result is valid only in the cycle done is high.
// MEM_WORDS must be a power of two; word addresses wrap modulo MEM_WORDS.
module lc3b_instruction_executor
    import lc3b_pkg::*;
#(
    parameter int MEM_WORDS = 32768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire item_t       item,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             done,
    output result_t          result
);

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FETCH = 6'b000100,
        S_DEC   = 6'b001000,
        S_RA    = 6'b010000,
        S_RB    = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg;
    logic [15:0]    start_pc_reg;
    logic [15:0]    pc_reg, pc_next;
    logic [2:0]     flags_reg, flags_next;
    logic [15:0]    ir_reg, a_reg, b_reg, ea_reg, ea_next;
    logic           done_reg, done_next;
    result_t        res_reg, res_next;

    logic [AW-1:0]  mem_addr;
    logic           mem_we;
    logic [15:0]    mem_wdata, mem_rdata;
    logic [2:0]     rf_addr;
    logic           rf_we;
    logic [15:0]    rf_wdata, rf_rdata;

    logic           accept;
    logic [3:0]     op;
    logic           is_store;
    logic [15:0]    sx5, sx6, sx9, sx11, opnd_b, npc, lo_byte_ext;
    logic [7:0]     ld_byte;
    logic [15:0]    wb_val;
    logic [2:0]     wb_idx;
    logic           wb_en, cc_en;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign result   = res_reg;
    assign op       = ir_reg[15:12];
    assign is_store = (op == OP_STB) || (op == OP_STW);

    assign sx5    = {{11{ir_reg[4]}}, ir_reg[4:0]};
    assign sx6    = {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign sx9    = {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign sx11   = {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign opnd_b = ir_reg[5] ? sx5 : b_reg;
    assign npc    = pc_reg + 16'd2;

    lc3b_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    lc3b_ram #(.WIDTH(16), .DEPTH(8)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .addr  (rf_addr),
        .wdata (rf_wdata),
        .rdata (rf_rdata)
    );

    // Effective address of the data access
    always_comb
    begin
        case (op)
            OP_LDB, OP_STB: ea_next = a_reg + sx6;
            OP_LDW:         ea_next = a_reg + {sx6[14:0], 1'b0};
            OP_STW:         ea_next = (a_reg + {sx6[14:0], 1'b0}) & 16'hFFFE;
            OP_TRAP:        ea_next = {7'd0, ir_reg[7:0], 1'b0};
            default:        ea_next = a_reg;
        endcase
    end

    // Execute with the data word in hand
    always_comb
    begin
        ld_byte     = ea_reg[0] ? mem_rdata[15:8] : mem_rdata[7:0];
        lo_byte_ext = {8'd0, b_reg[7:0]};
        wb_val      = 16'd0;
        wb_idx      = ir_reg[11:9];
        wb_en       = 1'b0;
        cc_en       = 1'b0;
        pc_next     = npc;
        case (op)
            OP_BR:
            begin
                if ((ir_reg[11:9] & flags_reg) != 3'd0)
                begin
                    pc_next = npc + {sx9[14:0], 1'b0};
                end
            end
            OP_ADD:
            begin
                wb_val = a_reg + opnd_b; wb_en = 1'b1; cc_en = 1'b1;
            end
            OP_AND:
            begin
                wb_val = a_reg & opnd_b; wb_en = 1'b1; cc_en = 1'b1;
            end
            OP_XOR:
            begin
                wb_val = a_reg ^ opnd_b; wb_en = 1'b1; cc_en = 1'b1;
            end
            OP_LDB:
            begin
                wb_val = {{8{ld_byte[7]}}, ld_byte}; wb_en = 1'b1; cc_en = 1'b1;
            end
            OP_LDW:
            begin
                wb_val = mem_rdata; wb_en = 1'b1; cc_en = 1'b1;
            end
            OP_JSR:
            begin
                wb_val = npc; wb_idx = 3'd7; wb_en = 1'b1;
                pc_next = ir_reg[11] ? (npc + {sx11[14:0], 1'b0}) : a_reg;
            end
            OP_JMP:
            begin
                pc_next = a_reg;
            end
            OP_SHF:
            begin
                if (!ir_reg[4])
                begin
                    wb_val = a_reg << ir_reg[3:0];
                end
                else if (ir_reg[5])
                begin
                    wb_val = 16'($signed(a_reg) >>> ir_reg[3:0]);
                end
                else
                begin
                    wb_val = a_reg >> ir_reg[3:0];
                end
                wb_en = 1'b1; cc_en = 1'b1;
            end
            OP_LEA:
            begin
                wb_val = npc + {sx9[14:0], 1'b0}; wb_en = 1'b1;
            end
            OP_TRAP:
            begin
                wb_val = npc; wb_idx = 3'd7; wb_en = 1'b1;
                pc_next = mem_rdata;
            end
            default:
            begin
                wb_en = 1'b0;
            end
        endcase
    end

    // Port control and next state
    always_comb
    begin
        state_next = state_reg;
        mem_addr   = pc_reg[AW:1];
        mem_we     = 1'b0;
        mem_wdata  = 16'd0;
        rf_addr    = 3'd0;
        rf_we      = 1'b0;
        rf_wdata   = 16'd0;
        flags_next = flags_reg;
        done_next  = 1'b0;
        res_next   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_addr = clr_reg;
                mem_we   = 1'b1;
                rf_addr  = clr_reg[2:0];
                rf_we    = 1'b1;
                if (clr_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && item.kind == KIND_LOAD)
                begin
                    mem_addr  = item.load_address[AW:1];
                    mem_we    = 1'b1;
                    mem_wdata = item.load_data;
                end
                if (accept && item.kind == KIND_STEP && pc_reg != 16'd0)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                rf_addr    = mem_rdata[8:6];
                state_next = S_DEC;
            end
            S_DEC:
            begin
                rf_addr    = is_store ? ir_reg[11:9] : ir_reg[2:0];
                state_next = S_RA;
            end
            S_RA:
            begin
                mem_addr   = ea_next[AW:1];
                state_next = S_RB;
            end
            S_RB:
            begin
                mem_addr = ea_reg[AW:1];
                if (op == OP_STB)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = ea_reg[0] ? {b_reg[7:0], mem_rdata[7:0]}
                                          : {mem_rdata[15:8], b_reg[7:0]};
                    res_next.mem_write        = 1'b1;
                    res_next.mem_byte_only    = 1'b1;
                    res_next.mem_byte_address = ea_reg;
                    res_next.mem_value        = lo_byte_ext;
                end
                else if (op == OP_STW)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = b_reg;
                    res_next.mem_write        = 1'b1;
                    res_next.mem_byte_address = ea_reg;
                    res_next.mem_value        = b_reg;
                end
                rf_addr  = wb_idx;
                rf_we    = wb_en;
                rf_wdata = wb_val;
                if (wb_en)
                begin
                    res_next.reg_write = 1'b1;
                    res_next.reg_index = wb_idx;
                    res_next.reg_value = wb_val;
                end
                if (cc_en)
                begin
                    flags_next = (wb_val == 16'd0) ? FLAGS_Z :
                                 (wb_val[15] ? FLAGS_N : FLAGS_P);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Restart and the finish of non-step transactions and refused steps
        if (state_reg == S_IDLE && accept)
        begin
            if (item.kind == KIND_RESTART)
            begin
                flags_next = FLAGS_Z;
            end
            if (item.kind != KIND_STEP || pc_reg == 16'd0)
            begin
                done_next       = 1'b1;
                res_next.halted = (item.kind == KIND_STEP);
            end
        end
        res_next.pc_after = (state_reg == S_RB) ? pc_next :
                            ((state_reg == S_IDLE && accept && item.kind == KIND_RESTART)
                             ? start_pc_reg : pc_reg);
        res_next.flag_n = flags_next[2];
        res_next.flag_z = flags_next[1];
        res_next.flag_p = flags_next[0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            start_pc_reg <= 16'd0;
            pc_reg       <= 16'd0;
            flags_reg    <= FLAGS_Z;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                start_pc_reg <= cfg_wdata;
            end
            pc_reg    <= res_next.pc_after;
            flags_reg <= flags_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
        begin
            ir_reg <= mem_rdata;
        end
        if (state_reg == S_DEC)
        begin
            a_reg <= rf_rdata;
        end
        if (state_reg == S_RA)
        begin
            b_reg  <= rf_rdata;
            ea_reg <= ea_next;
        end
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// File: sv/lc3b_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lc3b_checker
    import lc3b_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire item_t   item,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // Non-step transactions finish in the next cycle
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.kind != KIND_STEP |=> done)
        else $error("missing result after non-step transaction");

    // A refused step means the PC is zero
    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.halted |-> result.pc_after == 16'd0)
        else $error("halt reported with nonzero pc");

    // Exactly one flag is set
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({result.flag_n, result.flag_z, result.flag_p}))
        else $error("flags not one-hot");

    // Unused register fields stay zero
    a_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.reg_write |-> result.reg_index == 3'd0
                                      && result.reg_value == 16'd0)
        else $error("register fields set without a write");

endmodule

bind lc3b_instruction_executor lc3b_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
